// ----- rtl/core/fkts_pkg.sv -----
// types and constants shared by the floor key table search block
package fkts_pkg;

	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int LINE_W = 20;
	localparam int ST_W   = 2;
	localparam int IDX_W  = 8;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PROBE,
		S_CMP,
		S_DONE
	} state_t;

endpackage

// ----- rtl/core/fkts_ram.sv -----
// generic single write port, single read port ram with registered read
module fkts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/fkts_probe.sv -----
// binary search step unit: midpoint, key compare and next search bounds
module fkts_probe #(
	parameter int CW = 9
) (
	input  logic [CW-1:0]               lo,
	input  logic [CW-1:0]               hi_end,
	input  logic [fkts_pkg::KEY_W-1:0]  probe_key,
	input  logic [fkts_pkg::KEY_W-1:0]  target,
	output logic                        more,
	output logic [CW-1:0]               mid,
	output logic                        key_le,
	output logic [CW-1:0]               lo_nxt,
	output logic [CW-1:0]               hi_nxt
);

	import fkts_pkg::*;

	logic [CW-1:0] span_m1;

	// search range is [lo, hi_end), so it is live while lo is below hi_end
	assign more    = lo < hi_end;
	assign span_m1 = hi_end - lo - CW'(1);
	assign mid     = lo + (span_m1 >> 1);
	assign key_le  = probe_key <= target;

	always_comb begin
		lo_nxt = lo;
		hi_nxt = hi_end;
		if (key_le) begin
			lo_nxt = mid + CW'(1);
		end else begin
			hi_nxt = mid;
		end
	end

endmodule

// ----- rtl/core/floor_key_table_search.sv -----
// Floor key table search: a table of up to TABLE_DEPTH (key, line) entries held in one ram.
// Append writes the next slot, clear resets the entry count, and query runs a binary
// search for the entry with the largest key not above search_key. An accepted append,
// clear or unused opcode passes through S_EXEC to S_DONE, where its result is loaded into
// the output register once that is free. A query passes through S_EXEC and then makes at
// most floor(log2(entry count)) + 1 probes (none for an empty table); each probe is a ram
// read in S_PROBE followed by a compare in S_CMP in the shared step unit, and a last visit
// to S_PROBE sees the search end before S_DONE. One transaction is worked on at a time;
// a new one is taken while the previous result still waits in the output register.
module floor_key_table_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fkts_pkg::OP_W-1:0]   opcode,
	input  logic [fkts_pkg::KEY_W-1:0]  search_key,
	input  logic [fkts_pkg::LINE_W-1:0] entry_line,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fkts_pkg::ST_W-1:0]   status,
	output logic [fkts_pkg::LINE_W-1:0] found_line,
	output logic [fkts_pkg::IDX_W-1:0]  found_index
);

	import fkts_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = KEY_W + LINE_W;

	state_t state_q, state_nxt;

	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [LINE_W-1:0] line_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     lo_q, hi_q;
	logic              hit_q;
	logic [IW-1:0]     best_idx_q;
	logic [LINE_W-1:0] best_line_q;
	logic [ST_W-1:0]   res_status_q;
	logic [LINE_W-1:0] res_line_q;
	logic [IW-1:0]     res_idx_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [LINE_W-1:0] found_line_q;
	logic [IDX_W-1:0]  found_index_q;

	logic              in_fire, out_free, out_load;
	logic              ram_we, ram_re;
	logic [RW-1:0]     ram_rdata;
	logic              more, key_le;
	logic [CW-1:0]     mid, lo_nxt, hi_nxt;
	logic              table_full;
	logic [IW+IDX_W-1:0] idx_ext;

	assign table_full = count_q >= CW'(TABLE_DEPTH);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;

	fkts_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata ({key_q, line_q}),
		.re    (ram_re),
		.raddr (mid[IW-1:0]),
		.rdata (ram_rdata)
	);

	fkts_probe #(
		.CW (CW)
	) u_probe (
		.lo        (lo_q),
		.hi_end    (hi_q),
		.probe_key (ram_rdata[RW-1:LINE_W]),
		.target    (key_q),
		.more      (more),
		.mid       (mid),
		.key_le    (key_le),
		.lo_nxt    (lo_nxt),
		.hi_nxt    (hi_nxt)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_QUERY) state_nxt = S_PROBE;
				else state_nxt = S_DONE;
			end
			S_PROBE: begin
				if (more) state_nxt = S_CMP;
				else state_nxt = S_DONE;
			end
			S_CMP: begin
				state_nxt = S_PROBE;
			end
			S_DONE: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready = 1'b1;
			S_EXEC:  ram_we = (op_q == OP_APPEND) && !table_full;
			S_PROBE: ram_re = more;
			S_CMP:   ;
			S_DONE:  out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_EXEC) begin
			if (op_q == OP_CLEAR) begin
				count_q <= '0;
			end else if (op_q == OP_APPEND && !table_full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= opcode;
			key_q  <= search_key;
			line_q <= entry_line;
		end
		case (state_q)
			S_EXEC: begin
				lo_q         <= '0;
				hi_q         <= count_q;
				hit_q        <= 1'b0;
				res_status_q <= ST_OK;
				res_line_q   <= '0;
				res_idx_q    <= '0;
				if (op_q == OP_APPEND) begin
					if (table_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_idx_q <= count_q[IW-1:0];
					end
				end
			end
			S_PROBE: begin
				if (!more) begin
					if (hit_q) begin
						res_status_q <= ST_OK;
						res_line_q   <= best_line_q;
						res_idx_q    <= best_idx_q;
					end else begin
						res_status_q <= ST_MISS;
						res_line_q   <= '0;
						res_idx_q    <= '0;
					end
				end
			end
			S_CMP: begin
				lo_q <= lo_nxt;
				hi_q <= hi_nxt;
				// probed key not above target: it becomes the candidate
				if (key_le) begin
					hit_q       <= 1'b1;
					best_idx_q  <= mid[IW-1:0];
					best_line_q <= ram_rdata[LINE_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// low byte of the index, zero extended for small tables
	assign idx_ext = {{IDX_W{1'b0}}, res_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= res_status_q;
			found_line_q  <= res_line_q;
			found_index_q <= idx_ext[IDX_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_line  = found_line_q;
	assign found_index = found_index_q;

endmodule
